@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the psu_checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and default sizes of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int DEF_MAX_LINE_BYTES  = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 4;
    localparam int LINE_W     = 14;
    localparam int ROWS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_BYTES = 2'd0,
        CFG_LINE_BYTES  = 2'd1,
        CFG_IMAGE_ROWS  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_filter filter;
        logic    first_row;
        logic    has_left;
        logic    row_end;
        logic    image_end;
        logic    bad;
    } t_flags;

endpackage

@@ rtl/core/psu_ifs.sv @@
// ----------------------------------------------------------------------------
// psu_ifs
// Valid/ready channels of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
    modport source (output valid, output out_byte, output row_end, output image_end,
                    output bad_filter, input ready);
    modport sink   (input valid, input out_byte, input row_end, input image_end,
                    input bad_filter, output ready);
endinterface

interface psu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/psu_front.sv @@
// ----------------------------------------------------------------------------
// psu_front
// Accepts stream bytes, tracks row and image position, classifies each byte.
// ----------------------------------------------------------------------------
module psu_front #(
    parameter int MAX_LINE_BYTES  = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    localparam int CW = $clog2(MAX_LINE_BYTES),
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    psu_in_if.sink                     i_in,
    input  logic [psu_pkg::PIX_W-1:0]  i_pixel_bytes,
    input  logic [psu_pkg::LINE_W-1:0] i_line_bytes,
    input  logic [psu_pkg::ROWS_W-1:0] i_image_rows,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output logic [7:0]                 o_q_byte,
    output logic [CW-1:0]              o_q_col,
    output logic [PW-1:0]              o_q_sel,
    output psu_pkg::t_flags            o_q_flags
);
    localparam int LW = CW + 1;
    localparam int EW = (LW > psu_pkg::LINE_W) ? LW : psu_pkg::LINE_W;
    localparam int RW = psu_pkg::ROWS_W + 1;

    logic                       r_await;
    logic                       r_halted;
    logic [CW-1:0]              r_col;
    logic [psu_pkg::ROWS_W-1:0] r_row;
    psu_pkg::t_filter           r_filter;

    logic                      accept;
    logic                      is_bad;
    logic [EW-1:0]             line_ext;
    logic [EW-1:0]             len_ext;
    logic [LW-1:0]             eff_len;
    logic [CW-1:0]             col_eff;
    logic [LW-1:0]             col_next;
    logic                      row_end;
    logic [RW-1:0]             eff_rows;
    logic [RW-1:0]             row_next;
    logic                      image_end;
    logic [psu_pkg::PIX_W-1:0] bpp;

    assign i_in.ready = r_halted || !i_q_full;
    assign accept     = i_in.valid && i_in.ready && !r_halted;
    assign is_bad     = i_in.in_byte > 8'(psu_pkg::FILT_PAETH);

    always_comb begin
        line_ext = EW'(i_line_bytes);
        if (line_ext == '0) begin
            len_ext = EW'(1);
        end else if (line_ext > EW'(MAX_LINE_BYTES)) begin
            len_ext = EW'(MAX_LINE_BYTES);
        end else begin
            len_ext = line_ext;
        end
        eff_len = LW'(len_ext);
        col_eff = ({1'b0, r_col} >= eff_len) ? CW'(eff_len - LW'(1)) : r_col;
        col_next = {1'b0, col_eff} + LW'(1);
        row_end  = col_next >= eff_len;
        eff_rows = (i_image_rows == '0) ? RW'(1) : RW'(i_image_rows);
        row_next = RW'(r_row) + RW'(1);
        image_end = row_end && (row_next >= eff_rows);
        if (i_pixel_bytes == '0) begin
            bpp = psu_pkg::PIX_W'(1);
        end else if (i_pixel_bytes > psu_pkg::PIX_W'(MAX_PIXEL_BYTES)) begin
            bpp = psu_pkg::PIX_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp = i_pixel_bytes;
        end
    end

    always_comb begin
        o_q_push  = accept && (!r_await || is_bad);
        o_q_byte  = i_in.in_byte;
        o_q_col   = col_eff;
        o_q_sel   = PW'(bpp - psu_pkg::PIX_W'(1));
        o_q_flags.filter    = r_filter;
        o_q_flags.first_row = r_row == '0;
        o_q_flags.has_left  = col_eff >= CW'(bpp);
        o_q_flags.row_end   = !r_await && row_end;
        o_q_flags.image_end = !r_await && image_end;
        o_q_flags.bad       = r_await;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_halted <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_filter <= psu_pkg::FILT_NONE;
        end else if (accept) begin
            if (r_await) begin
                if (is_bad) begin
                    r_halted <= 1'b1;
                end else begin
                    r_filter <= psu_pkg::t_filter'(i_in.in_byte[2:0]);
                    r_await  <= 1'b0;
                    r_col    <= '0;
                end
            end else if (row_end) begin
                r_await <= 1'b1;
                r_col   <= '0;
                r_row   <= image_end ? '0 : psu_pkg::ROWS_W'(row_next);
            end else begin
                r_col <= CW'(col_next);
            end
        end
    end
endmodule

@@ rtl/core/psu_queue.sv @@
// ----------------------------------------------------------------------------
// psu_queue
// Short FIFO between the classifying front and the reconstructing back.
// ----------------------------------------------------------------------------
module psu_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    localparam int DEPTH = psu_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    logic [DW-1:0] r_slot [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [NW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end
endmodule

@@ rtl/core/psu_back.sv @@
// ----------------------------------------------------------------------------
// psu_back
// Reads the prior row, reconstructs each byte and drives the result register.
// ----------------------------------------------------------------------------
module psu_back #(
    parameter int MAX_LINE_BYTES  = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES,
    localparam int CW = $clog2(MAX_LINE_BYTES),
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  logic [7:0]      i_q_byte,
    input  logic [CW-1:0]   i_q_col,
    input  logic [PW-1:0]   i_q_sel,
    input  psu_pkg::t_flags i_q_flags,
    output logic            o_q_pop,
    psu_out_if.source       o_out
);
    localparam int WIN_W = 8 * MAX_PIXEL_BYTES;
    localparam int WW    = $clog2(WIN_W);

    logic [7:0]      r_prior [MAX_LINE_BYTES];
    logic [7:0]      r_rd;
    logic            r_byp_hit;
    logic [7:0]      r_byp;

    logic            r_s_valid;
    logic [7:0]      r_s_byte;
    logic [CW-1:0]   r_s_col;
    logic [PW-1:0]   r_s_sel;
    psu_pkg::t_flags r_s_flags;

    logic [WIN_W-1:0] r_left;
    logic [WIN_W-1:0] r_upleft;

    logic            r_o_valid;
    logic [7:0]      r_o_byte;
    logic            r_o_row_end;
    logic            r_o_image_end;
    logic            r_o_bad;

    logic          out_load;
    logic          s_adv;
    logic          s_load;
    logic          wr_en;
    logic [WW-1:0] win_base;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [8:0]    ab_sum;
    logic [7:0]    x;

    function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                         input logic [7:0] pa_c);
        logic signed [9:0] d_a;
        logic signed [9:0] d_b;
        logic signed [9:0] d_c;
        logic [7:0]        pick;
        d_a = $signed({2'b00, pa_b}) - $signed({2'b00, pa_c});
        d_b = $signed({2'b00, pa_a}) - $signed({2'b00, pa_c});
        d_c = d_a + d_b;
        if (d_a < 0) d_a = -d_a;
        if (d_b < 0) d_b = -d_b;
        if (d_c < 0) d_c = -d_c;
        if (d_a <= d_b && d_a <= d_c) begin
            pick = pa_a;
        end else if (d_b <= d_c) begin
            pick = pa_b;
        end else begin
            pick = pa_c;
        end
        return pick;
    endfunction

    assign out_load = !r_o_valid || o_out.ready;
    assign s_adv    = r_s_valid && out_load;
    assign s_load   = !r_s_valid || s_adv;
    assign o_q_pop  = i_q_valid && s_load;
    assign wr_en    = s_adv && !r_s_flags.bad;
    assign win_base = WW'({r_s_sel, 3'b000});

    always_comb begin
        a = r_s_flags.has_left ? r_left[win_base +: 8] : 8'd0;
        c = r_s_flags.has_left ? r_upleft[win_base +: 8] : 8'd0;
        if (r_s_flags.first_row) begin
            b = 8'd0;
        end else begin
            b = r_byp_hit ? r_byp : r_rd;
        end
        ab_sum = {1'b0, a} + {1'b0, b};
        case (r_s_flags.filter)
            psu_pkg::FILT_SUB:   x = r_s_byte + a;
            psu_pkg::FILT_UP:    x = r_s_byte + b;
            psu_pkg::FILT_AVG:   x = r_s_byte + ab_sum[8:1];
            psu_pkg::FILT_PAETH: x = r_s_byte + paeth(a, b, c);
            default:             x = r_s_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_prior[r_s_col] <= x;
        end
        if (o_q_pop) begin
            r_rd      <= r_prior[i_q_col];
            r_byp_hit <= wr_en && (r_s_col == i_q_col);
            r_byp     <= x;
            r_s_byte  <= i_q_byte;
            r_s_col   <= i_q_col;
            r_s_sel   <= i_q_sel;
            r_s_flags <= i_q_flags;
        end
        if (wr_en) begin
            r_left   <= (r_left << 8) | WIN_W'(x);
            r_upleft <= (r_upleft << 8) | WIN_W'(b);
        end
        if (s_adv) begin
            r_o_byte      <= r_s_flags.bad ? 8'd0 : x;
            r_o_row_end   <= r_s_flags.row_end;
            r_o_image_end <= r_s_flags.image_end;
            r_o_bad       <= r_s_flags.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_load) begin
                r_s_valid <= i_q_valid;
            end
            if (out_load) begin
                r_o_valid <= s_adv;
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.out_byte   = r_o_byte;
    assign o_out.row_end    = r_o_row_end;
    assign o_out.image_end  = r_o_image_end;
    assign o_out.bad_filter = r_o_bad;
endmodule

@@ rtl/core/png_scanline_unfilter_top.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG filter reconstruction (None, Sub, Up, Average, Paeth) on a byte stream.
// ----------------------------------------------------------------------------
// Channels: i_in carries the decompressed stream, one byte per transaction:
// a filter type byte, then line_bytes data bytes, row after row. o_out carries
// one result per data byte with row_end and image_end marks; a type byte
// yields none. A type above 4 yields one result with bad_filter set, after
// which every input transaction is taken and dropped until reset.
// i_cfg writes pixel_bytes (index 0), line_bytes (1) and image_rows (2); the
// user must write them only while the block is idle, which the block does not
// enforce; i_cfg is always ready. Throughput: one byte per cycle while o_out
// is ready. A data byte passes the queue, the prior-row read stage and the
// result register to o_out; the prior-row read is registered as the byte
// enters the read stage; the left-neighbor feedback closes within that stage.
// Reset: synchronous, active low; config registers return to 1, the stream
// expects a type byte, the prior-row store keeps its contents and is not
// cleared.
// Stall: o_out holds its result while ready is low; the result register, read
// stage and two-entry queue absorb up to four results, then i_in.ready drops.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
    parameter int MAX_LINE_BYTES  = psu_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psu_in_if.sink    i_in,
    psu_out_if.source o_out,
    psu_cfg_if.sink   i_cfg
);
    localparam int CW = $clog2(MAX_LINE_BYTES);
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int FW = $bits(psu_pkg::t_flags);
    localparam int DW = 8 + CW + PW + FW;

    logic [psu_pkg::PIX_W-1:0]  r_pixel_bytes;
    logic [psu_pkg::LINE_W-1:0] r_line_bytes;
    logic [psu_pkg::ROWS_W-1:0] r_image_rows;

    logic            q_full;
    logic            q_push;
    logic [7:0]      push_byte;
    logic [CW-1:0]   push_col;
    logic [PW-1:0]   push_sel;
    psu_pkg::t_flags push_flags;
    logic            q_pop;
    logic            q_valid;
    logic [DW-1:0]   q_head;
    logic [7:0]      head_byte;
    logic [CW-1:0]   head_col;
    logic [PW-1:0]   head_sel;
    psu_pkg::t_flags head_flags;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= psu_pkg::PIX_W'(1);
            r_line_bytes  <= psu_pkg::LINE_W'(1);
            r_image_rows  <= psu_pkg::ROWS_W'(1);
        end else if (i_cfg.valid) begin
            case (psu_pkg::t_cfg_idx'(i_cfg.index))
                psu_pkg::CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg.data[psu_pkg::PIX_W-1:0];
                psu_pkg::CFG_LINE_BYTES:  r_line_bytes  <= i_cfg.data[psu_pkg::LINE_W-1:0];
                psu_pkg::CFG_IMAGE_ROWS:  r_image_rows  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    psu_front #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_pixel_bytes (r_pixel_bytes),
        .i_line_bytes  (r_line_bytes),
        .i_image_rows  (r_image_rows),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_byte      (push_byte),
        .o_q_col       (push_col),
        .o_q_sel       (push_sel),
        .o_q_flags     (push_flags)
    );

    psu_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_byte, push_col, push_sel, push_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign {head_byte, head_col, head_sel, head_flags} = q_head;

    psu_back #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_byte  (head_byte),
        .i_q_col   (head_col),
        .i_q_sel   (head_sel),
        .i_q_flags (head_flags),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule

@@ rtl/core/psu_checker.sv @@
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks of the PNG scanline unfilter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_row_end,
    input logic       i_image_end,
    input logic       i_bad_filter
);
    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) && $stable(i_row_end) && $stable(i_image_end) && $stable(i_bad_filter)), "result changed while stalled")
    `ASSERT_CLK(a_bad_clean, i_clk, i_rst_n, (i_out_valid && i_bad_filter) |-> (i_out_byte == 8'd0 && !i_row_end && !i_image_end), "bad_filter result carries data")
    `ASSERT_CLK(a_image_row, i_clk, i_rst_n, (i_out_valid && i_image_end) |-> i_row_end, "image end without row end")
    `ASSERT_CLK(a_halt, i_clk, i_rst_n, (out_xfer && i_bad_filter) |=> !i_out_valid, "result after bad_filter")
endmodule

bind png_scanline_unfilter_top psu_checker u_psu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_row_end    (o_out.row_end),
    .i_image_end  (o_out.image_end),
    .i_bad_filter (o_out.bad_filter)
);

@@ test/psu_unfilter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psu_unfilter_checker
// Watches the input, output and register channels of the PNG scanline
// unfilter. It rebuilds every image byte from the accepted stream and compares
// each output transaction, field by field, with the oldest expected byte.
// ----------------------------------------------------------------------------
module psu_unfilter_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    psu_in_if    i_in_mon,
    psu_out_if   i_out_mon,
    psu_cfg_if   i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int CW = $clog2(psu_pkg::DEF_MAX_LINE_BYTES);

    typedef struct packed {
        logic [psu_pkg::BYTE_W-1:0] out_byte;
        logic                       row_end;
        logic                       image_end;
        logic                       bad_filter;
    } t_pixel_byte;

    t_pixel_byte                recon_q[$];

    logic [psu_pkg::PIX_W-1:0]  pix_reg;
    logic [psu_pkg::LINE_W-1:0] line_reg;
    logic [psu_pkg::ROWS_W-1:0] rows_reg;

    logic [psu_pkg::BYTE_W-1:0] prior_row [psu_pkg::DEF_MAX_LINE_BYTES];
    logic [63:0]                left_win;
    logic [63:0]                upleft_win;
    int                         column;
    int                         row_count;
    psu_pkg::t_filter           row_filter;
    bit                         await_type;
    bit                         halted;

    task automatic unfilter_byte(input logic [psu_pkg::BYTE_W-1:0] raw);
        int          bpp;
        int          len;
        int          rows;
        int          a_i;
        int          b_i;
        int          c_i;
        int          p;
        int          pa;
        int          pb;
        int          pc;
        int          pred;
        logic [CW-1:0] col_idx;
        logic [7:0]  x;
        t_pixel_byte res;
        if (halted) begin
            return;
        end
        if (await_type) begin
            if (raw > psu_pkg::BYTE_W'(psu_pkg::FILT_PAETH)) begin
                halted = 1'b1;
                res = '{out_byte: '0, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
                recon_q.push_back(res);
                return;
            end
            row_filter = psu_pkg::t_filter'(raw[2:0]);
            await_type = 1'b0;
            column     = 0;
            left_win   = '0;
            upleft_win = '0;
            return;
        end
        bpp  = (pix_reg == 0) ? 1 :
               (int'(pix_reg) > psu_pkg::DEF_MAX_PIXEL_BYTES) ?
               psu_pkg::DEF_MAX_PIXEL_BYTES : int'(pix_reg);
        len  = (line_reg == 0) ? 1 :
               (int'(line_reg) > psu_pkg::DEF_MAX_LINE_BYTES) ?
               psu_pkg::DEF_MAX_LINE_BYTES : int'(line_reg);
        rows = (rows_reg == 0) ? 1 : int'(rows_reg);
        if (column >= len) begin
            column = len - 1;
        end
        col_idx = CW'(column);
        b_i = (row_count == 0) ? 0 : int'(prior_row[col_idx]);
        if (column >= bpp) begin
            a_i = int'(8'(left_win >> ((bpp - 1) * 8)));
            c_i = int'(8'(upleft_win >> ((bpp - 1) * 8)));
        end else begin
            a_i = 0;
            c_i = 0;
        end
        case (row_filter)
            psu_pkg::FILT_SUB:   pred = a_i;
            psu_pkg::FILT_UP:    pred = b_i;
            psu_pkg::FILT_AVG:   pred = (a_i + b_i) >> 1;
            psu_pkg::FILT_PAETH: begin
                p  = a_i + b_i - c_i;
                pa = (p >= a_i) ? p - a_i : a_i - p;
                pb = (p >= b_i) ? p - b_i : b_i - p;
                pc = (p >= c_i) ? p - c_i : c_i - p;
                if (pa <= pb && pa <= pc) begin
                    pred = a_i;
                end else if (pb <= pc) begin
                    pred = b_i;
                end else begin
                    pred = c_i;
                end
            end
            default:    pred = 0;
        endcase
        x = 8'(int'(raw) + pred);
        prior_row[col_idx] = x;
        left_win   = {left_win[55:0], x};
        upleft_win = {upleft_win[55:0], 8'(b_i)};
        res = '{out_byte: x, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b0};
        if (column + 1 >= len) begin
            res.row_end = 1'b1;
            await_type  = 1'b1;
            column      = 0;
            if (row_count + 1 >= rows) begin
                res.image_end = 1'b1;
                row_count     = 0;
            end else begin
                row_count = row_count + 1;
            end
        end else begin
            column = column + 1;
        end
        recon_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_pixel_byte want;
        if (!i_rst_n) begin
            pix_reg    = psu_pkg::PIX_W'(1);
            line_reg   = psu_pkg::LINE_W'(1);
            rows_reg   = psu_pkg::ROWS_W'(1);
            left_win   = '0;
            upleft_win = '0;
            column     = 0;
            row_count  = 0;
            row_filter = psu_pkg::FILT_NONE;
            await_type = 1'b1;
            halted     = 1'b0;
            recon_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (recon_q.size() == 0) begin
                    $error("unexpected transaction: out_byte %0h row_end %0b %s %0b %s %0b",
                           i_out_mon.out_byte, i_out_mon.row_end,
                           "image_end", i_out_mon.image_end,
                           "bad_filter", i_out_mon.bad_filter);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = recon_q.pop_front();
                    if (i_out_mon.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h",
                               want.out_byte, i_out_mon.out_byte);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_mon.row_end !== want.row_end) begin
                        $error("row_end: expected %0b, actual %0b",
                               want.row_end, i_out_mon.row_end);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_mon.image_end !== want.image_end) begin
                        $error("image_end: expected %0b, actual %0b",
                               want.image_end, i_out_mon.image_end);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_mon.bad_filter !== want.bad_filter) begin
                        $error("bad_filter: expected %0b, actual %0b",
                               want.bad_filter, i_out_mon.bad_filter);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (psu_pkg::t_cfg_idx'(i_cfg_mon.index))
                    psu_pkg::CFG_PIXEL_BYTES:
                        pix_reg  = i_cfg_mon.data[psu_pkg::PIX_W-1:0];
                    psu_pkg::CFG_LINE_BYTES:
                        line_reg = i_cfg_mon.data[psu_pkg::LINE_W-1:0];
                    psu_pkg::CFG_IMAGE_ROWS:
                        rows_reg = i_cfg_mon.data[psu_pkg::ROWS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                unfilter_byte(i_in_mon.in_byte);
            end
        end
        o_pending = recon_q.size();
    end

endmodule

@@ test/png_scanline_unfilter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top_tb
// Drives filtered PNG rows into the scanline unfilter: a directed pass over
// every filter type, register limits and changes within a row and an image,
// then random images under three idling patterns, one image with the widest
// pixel and a bad filter type at the very end. A checker beside the block
// predicts and compares every result; this module only makes stimulus and
// the verdict.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top_tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;

    psu_in_if  in_ch ();
    psu_out_if out_ch ();
    psu_cfg_if cfg_ch ();

    int fail_count;
    int pending_cnt;
    int cycle_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    int line_eff;
    int rows_eff;

    png_scanline_unfilter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    psu_unfilter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= value;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // hold input until every result is out and the pipeline has emptied
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_cnt != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input psu_pkg::t_cfg_idx idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        case (idx)
            psu_pkg::CFG_LINE_BYTES: begin
                line_eff = (value[psu_pkg::LINE_W-1:0] == 0) ? 1 :
                           (int'(value[psu_pkg::LINE_W-1:0]) > psu_pkg::DEF_MAX_LINE_BYTES) ?
                           psu_pkg::DEF_MAX_LINE_BYTES : int'(value[psu_pkg::LINE_W-1:0]);
            end
            psu_pkg::CFG_IMAGE_ROWS: rows_eff = (value == 0) ? 1 : int'(value);
            default: ;
        endcase
    endtask

    task automatic send_rows(input int n_rows);
        logic [7:0] data;
        for (int r = 0; r < n_rows; r++) begin
            push_byte(8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH)));
            for (int i = 0; i < line_eff; i++) begin
                case ($urandom_range(7))
                    0:       data = 8'h00;
                    1:       data = 8'hFF;
                    default: data = 8'($urandom);
                endcase
                push_byte(data);
            end
        end
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        logic [15:0] pix_v;
        logic [15:0] line_v;
        logic [15:0] rows_v;
        sent = 0;
        while (sent < n_items) begin
            drain_results();
            case ($urandom_range(9))
                0:       pix_v = 16'd0;
                1:       pix_v = 16'd8;
                2:       pix_v = 16'd1;
                3:       pix_v = 16'($urandom_range(9, 15));
                default: pix_v = 16'($urandom_range(1, 8));
            endcase
            pix_v[15:psu_pkg::PIX_W] = 12'($urandom);
            case ($urandom_range(9))
                0:       line_v = 16'd0;
                1:       line_v = 16'd1;
                2:       line_v = 16'($urandom_range(25, 64));
                default: line_v = 16'($urandom_range(2, 24));
            endcase
            line_v[15:psu_pkg::LINE_W] = 2'($urandom);
            rows_v = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            write_reg(psu_pkg::CFG_PIXEL_BYTES, pix_v);
            write_reg(psu_pkg::CFG_LINE_BYTES, line_v);
            write_reg(psu_pkg::CFG_IMAGE_ROWS, rows_v);
            repeat ($urandom_range(1, 3)) begin
                send_rows(rows_eff);
                sent += rows_eff * (line_eff + 1);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = psu_pkg::CFG_PIXEL_BYTES;
        cfg_ch.data   = '0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        line_eff      = 1;
        rows_eff      = 1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // one-byte rows, one row per image, as after reset
        push_byte(8'(psu_pkg::FILT_NONE));
        push_byte(8'hFF);

        drain_results();
        write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'd1);
        write_reg(psu_pkg::CFG_LINE_BYTES, 16'd3);
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd5);
        for (int f = psu_pkg::FILT_NONE; f <= psu_pkg::FILT_PAETH; f++) begin
            push_byte(8'(f));
            push_byte(8'hFF);
            push_byte(8'h00);
            push_byte(8'h80);
        end

        // shrink the row mid-row, then end the image early
        drain_results();
        write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'd2);
        write_reg(psu_pkg::CFG_LINE_BYTES, 16'd4);
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd3);
        push_byte(8'(psu_pkg::FILT_PAETH));
        push_byte(8'h01);
        push_byte(8'hFE);
        push_byte(8'h7F);
        drain_results();
        write_reg(psu_pkg::CFG_LINE_BYTES, 16'd2);
        push_byte(8'h80);
        drain_results();
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd1);
        push_byte(8'(psu_pkg::FILT_AVG));
        push_byte(8'hFF);
        push_byte(8'h00);

        drain_results();
        write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'd2);
        write_reg(psu_pkg::CFG_LINE_BYTES, 16'd5);
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'hFFFF);
        send_rows(3);
        drain_results();
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd0);
        send_rows(1);

        run_random(300);

        send_idle_pct = 74;
        recv_idle_pct = 13;
        run_random(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(300);

        // widest pixel; register bits above each field are ignored
        drain_results();
        write_reg(psu_pkg::CFG_PIXEL_BYTES, 16'hFFFF);
        write_reg(psu_pkg::CFG_LINE_BYTES, 16'hC010);
        write_reg(psu_pkg::CFG_IMAGE_ROWS, 16'd2);
        send_rows(rows_eff);

        // bad filter type halts the block; the bytes after it are dropped
        drain_results();
        push_byte(8'($urandom_range(psu_pkg::FILT_PAETH + 1, 255)));
        repeat (6) push_byte(8'($urandom));
        in_ch.valid <= 1'b0;

        while (pending_cnt != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
